FILE: rtl/brav_pkg.sv
// Shared types and fixed constants for the block range average query engine.
package brav_pkg;

    // Field widths fixed by the item format.
    localparam int IDX_W   = 10;
    localparam int SMP_W   = 16;
    localparam int AVG_W   = 24;
    localparam int CFG_W   = 11;
    localparam int FRAC_W  = 8;
    localparam int POS_W   = IDX_W + 1;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SAMPLE_COUNT = 1'b0;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_CLEAR,
        S_LOCATE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_WALK,
        S_SETUP,
        S_DIVIDE,
        S_FINISH
    } t_state;

    // Which store a read issued in the previous cycle came from.
    typedef struct packed {
        logic smp;
        logic blk;
    } t_pend;

endpackage

FILE: rtl/brav_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module brav_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/block_range_average_query.sv
// Top level of the block range average query engine: sample store, block sums and sequencer.
//
// The engine keeps up to MAX_SAMPLES signed 16-bit samples together with an exact
// running sum for each block of block_length consecutive samples, where
// block_length is the integer square root of the configured sample_count. An item
// is taken on a rising edge with start high and busy low; for an item in range,
// busy then stays high until the item is finished, and its single result beat
// appears on the result ports for exactly one cycle, marked by o_valid. The
// receiver cannot stall that beat, so it must be ready to take it whenever it
// arrives; the next item may be started in the very cycle the result is shown.
// In a load the block number is found by repeated subtraction, then the old
// sample and block sum are read and written back. A query finds its block in
// the same way, then takes one walk step per single sample in the leading and
// trailing partial blocks and one per whole block (at most about three times
// block_length steps), and ends in a restoring divider that produces one
// quotient bit per cycle. Rejected items leave busy low and are answered in the
// cycle after they are taken, with o_bad_index set and a zero average. After
// reset, and after every write of sample_count, the engine first computes the
// square root and then clears both stores one address per cycle over
// max(MAX_SAMPLES, MAX_BLOCKS) addresses (1024 with the default parameters);
// busy is high throughout, while configuration writes are still taken and
// simply restart the sequence. The APB-style port holds one register,
// sample_count, at byte address 0; pready is always high.
module block_range_average_query #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_BLOCKS  = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [brav_pkg::PADDR_W-1:0]        paddr,
    input  logic [brav_pkg::PDATA_W-1:0]        pwdata,
    output logic [brav_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Command handshake
    input  logic                                start,
    output logic                                busy,
    // Input item
    input  logic                                i_kind,
    input  logic signed [brav_pkg::SMP_W-1:0]   i_sample_value,
    input  logic [brav_pkg::IDX_W-1:0]          i_first_index,
    input  logic [brav_pkg::IDX_W-1:0]          i_last_index,
    // Result beat
    output logic                                o_valid,
    output logic signed [brav_pkg::AVG_W-1:0]   o_average,
    output logic                                o_bad_index
);

    import brav_pkg::*;

    // Derived sizes.
    localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int BW     = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int BL_W   = CNT_W / 2 + 1;
    localparam int SQ_W   = 2 * BL_W + 1;
    localparam int SUM_W  = SMP_W + $clog2(MAX_SAMPLES);
    localparam int CLR_N  = (MAX_SAMPLES > MAX_BLOCKS) ? MAX_SAMPLES : MAX_BLOCKS;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int DVD_W  = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DVD_W);

    // Sequencer and datapath registers.
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count;
    logic [BL_W-1:0]           r_blen, n_blen;
    logic [BL_W-1:0]           r_root, n_root;
    logic [SQ_W-1:0]           r_sq, n_sq;
    logic [CLR_W-1:0]          r_clr, n_clr;
    logic                      r_kind, n_kind;
    logic signed [SMP_W-1:0]   r_value, n_value;
    logic [IDX_W-1:0]          r_lo, n_lo;
    logic [IDX_W-1:0]          r_hi, n_hi;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [POS_W-1:0]          r_blk, n_blk;
    logic [POS_W-1:0]          r_rem, n_rem;
    logic [BL_W-1:0]           r_off, n_off;
    t_pend                     r_pend, n_pend;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [POS_W-1:0]          r_num, n_num;
    logic [POS_W-1:0]          r_part, n_part;
    logic [DVD_W-1:0]          r_dvd, n_dvd;
    logic [STEP_W-1:0]         r_step, n_step;
    logic                      r_neg, n_neg;
    logic                      r_valid, n_valid;
    logic signed [AVG_W-1:0]   r_avg, n_avg;
    logic                      r_bad, n_bad;

    // Store ports.
    logic                      smp_we;
    logic [AW-1:0]             smp_waddr, smp_raddr;
    logic [SMP_W-1:0]          smp_wdata, smp_rdata;
    logic                      bsm_we;
    logic [BW-1:0]             bsm_waddr, bsm_raddr;
    logic [SUM_W-1:0]          bsm_wdata, bsm_rdata;

    // Handshakes and small decisions.
    logic                      cfg_wr;
    logic [31:0]               cfg_raw;
    logic [CNT_W-1:0]          cfg_count;
    logic                      accept;
    logic                      item_bad;
    logic                      walk_done;
    logic                      whole_block;
    logic                      locate_done;
    logic [POS_W:0]            trial;
    logic                      trial_ge;
    logic signed [SUM_W-1:0]   walk_term;
    logic [SUM_W-1:0]          sum_mag;
    logic [AVG_W-1:0]          quot;

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_SAMPLE_COUNT);

    // A written count of zero is taken as one, anything above the store as the store size.
    always_comb begin
        cfg_raw = 32'(pwdata[CFG_W-1:0]);
        if (cfg_raw == 32'd0) begin
            cfg_raw = 32'd1;
        end else if (cfg_raw > 32'(MAX_SAMPLES)) begin
            cfg_raw = 32'(MAX_SAMPLES);
        end
        cfg_count = CNT_W'(cfg_raw);
    end

    assign pready = 1'b1;
    assign prdata = PDATA_W'(r_count);

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (i_kind == KIND_LOAD) begin
            item_bad = (32'(i_first_index) >= 32'(r_count));
        end else begin
            item_bad = (i_first_index > i_last_index)
                       || (32'(i_last_index) >= 32'(r_count));
        end
    end

    assign locate_done = (r_rem < POS_W'(r_blen));
    assign walk_done   = (r_pos > POS_W'(r_hi));

    // A whole block is summed through its stored sum when the walk sits on a block
    // boundary, the block lies entirely inside the range and it has a stored sum.
    assign whole_block = (r_off == BL_W'(0))
                         && (32'(r_blk) < MAX_BLOCKS)
                         && ((POS_W + 1)'(r_pos) + (POS_W + 1)'(r_blen)
                             <= (POS_W + 1)'(r_hi) + (POS_W + 1)'(1));

    always_comb begin
        walk_term = '0;
        if (r_pend.smp) begin
            walk_term = SUM_W'($signed(smp_rdata));
        end else if (r_pend.blk) begin
            walk_term = $signed(bsm_rdata);
        end
    end

    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign trial    = {r_part, r_dvd[DVD_W-1]};
    assign trial_ge = (trial >= (POS_W + 1)'(r_num));
    assign quot     = r_dvd[AVG_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !item_bad) begin
                    n_state = S_LOCATE;
                end
            end
            S_ROOT: begin
                if (32'(r_sq) > 32'(r_count)) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_LOCATE: begin
                if (locate_done) begin
                    n_state = (r_kind == KIND_LOAD) ? S_LOAD_RD : S_WALK;
                end
            end
            S_LOAD_RD: n_state = S_LOAD_WR;
            S_LOAD_WR: n_state = S_IDLE;
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP:   n_state = S_DIVIDE;
            S_DIVIDE: begin
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
        if (cfg_wr) begin
            n_state = S_ROOT;
        end
    end

    // Datapath and store controls.
    always_comb begin
        n_blen  = r_blen;
        n_root  = r_root;
        n_sq    = r_sq;
        n_clr   = r_clr;
        n_kind  = r_kind;
        n_value = r_value;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_pos   = r_pos;
        n_blk   = r_blk;
        n_rem   = r_rem;
        n_off   = r_off;
        n_pend  = '0;
        n_sum   = r_sum;
        n_num   = r_num;
        n_part  = r_part;
        n_dvd   = r_dvd;
        n_step  = r_step;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_avg   = r_avg;
        n_bad   = r_bad;

        smp_we    = 1'b0;
        smp_waddr = AW'(r_lo);
        smp_wdata = r_value;
        smp_raddr = AW'(r_pos);
        bsm_we    = 1'b0;
        bsm_waddr = BW'(r_blk);
        bsm_wdata = SUM_W'(bsm_rdata + SUM_W'(r_value) - SUM_W'($signed(smp_rdata)));
        bsm_raddr = BW'(r_blk);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind  = i_kind;
                    n_value = i_sample_value;
                    n_lo    = i_first_index;
                    n_hi    = i_last_index;
                    n_pos   = POS_W'(i_first_index);
                    n_rem   = POS_W'(i_first_index);
                    n_blk   = '0;
                    n_sum   = '0;
                    if (item_bad) begin
                        n_valid = 1'b1;
                        n_avg   = '0;
                        n_bad   = 1'b1;
                    end
                end
            end
            S_ROOT: begin
                // Step the root while the next square still fits the count.
                if (32'(r_sq) <= 32'(r_count)) begin
                    n_root = r_root + BL_W'(1);
                    n_sq   = r_sq + SQ_W'({r_root, 1'b0}) + SQ_W'(3);
                end else begin
                    n_blen = r_root;
                    n_clr  = '0;
                end
            end
            S_CLEAR: begin
                smp_we    = (32'(r_clr) < MAX_SAMPLES);
                smp_waddr = AW'(r_clr);
                smp_wdata = '0;
                bsm_we    = (32'(r_clr) < MAX_BLOCKS);
                bsm_waddr = BW'(r_clr);
                bsm_wdata = '0;
                n_clr     = r_clr + CLR_W'(1);
            end
            S_LOCATE: begin
                // Block number and offset of the first index by repeated subtraction.
                if (locate_done) begin
                    n_off = BL_W'(r_rem);
                end else begin
                    n_rem = r_rem - POS_W'(r_blen);
                    n_blk = r_blk + POS_W'(1);
                end
            end
            S_LOAD_RD: begin
                smp_raddr = AW'(r_lo);
            end
            S_LOAD_WR: begin
                smp_we  = 1'b1;
                bsm_we  = (32'(r_blk) < MAX_BLOCKS);
                n_valid = 1'b1;
                n_avg   = '0;
                n_bad   = 1'b0;
            end
            S_WALK: begin
                n_sum = r_sum + walk_term;
                if (!walk_done) begin
                    if (whole_block) begin
                        n_pend.blk = 1'b1;
                        n_pos      = r_pos + POS_W'(r_blen);
                        n_blk      = r_blk + POS_W'(1);
                    end else begin
                        n_pend.smp = 1'b1;
                        n_pos      = r_pos + POS_W'(1);
                        if (r_off == r_blen - BL_W'(1)) begin
                            n_off = '0;
                            n_blk = r_blk + POS_W'(1);
                        end else begin
                            n_off = r_off + BL_W'(1);
                        end
                    end
                end
            end
            S_SETUP: begin
                n_neg  = r_sum[SUM_W-1];
                n_dvd  = {sum_mag, FRAC_W'(0)};
                n_num  = POS_W'(r_hi) - POS_W'(r_lo) + POS_W'(1);
                n_part = '0;
                n_step = '0;
            end
            S_DIVIDE: begin
                // One restoring step: shift in a dividend bit, subtract when it fits.
                if (trial_ge) begin
                    n_part = POS_W'(trial - (POS_W + 1)'(r_num));
                end else begin
                    n_part = POS_W'(trial);
                end
                n_dvd  = {r_dvd[DVD_W-2:0], trial_ge};
                n_step = r_step + STEP_W'(1);
            end
            S_FINISH: begin
                n_valid = 1'b1;
                n_avg   = r_neg ? AVG_W'(-quot) : AVG_W'(quot);
                n_bad   = 1'b0;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase

        if (cfg_wr) begin
            n_root = '0;
            n_sq   = SQ_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ROOT;
            r_count <= CNT_W'(1);
            r_root  <= '0;
            r_sq    <= SQ_W'(1);
            r_clr   <= '0;
            r_pend  <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_count <= cfg_count;
            end
            r_root  <= n_root;
            r_sq    <= n_sq;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_blen  <= n_blen;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_pos   <= n_pos;
        r_blk   <= n_blk;
        r_rem   <= n_rem;
        r_off   <= n_off;
        r_sum   <= n_sum;
        r_num   <= n_num;
        r_part  <= n_part;
        r_dvd   <= n_dvd;
        r_neg   <= n_neg;
        r_avg   <= n_avg;
        r_bad   <= n_bad;
    end

    brav_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_SAMPLES),
        .ADDR_W(AW)
    ) u_sample_ram (
        .i_clk  (i_clk),
        .i_we   (smp_we),
        .i_waddr(smp_waddr),
        .i_wdata(smp_wdata),
        .i_raddr(smp_raddr),
        .o_rdata(smp_rdata)
    );

    brav_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_BLOCKS),
        .ADDR_W(BW)
    ) u_block_sum_ram (
        .i_clk  (i_clk),
        .i_we   (bsm_we),
        .i_waddr(bsm_waddr),
        .i_wdata(bsm_wdata),
        .i_raddr(bsm_raddr),
        .o_rdata(bsm_rdata)
    );

    assign o_valid     = r_valid;
    assign o_average   = r_avg;
    assign o_bad_index = r_bad;

endmodule

FILE: tb/tb_block_range_average_query.sv
// Self-checking testbench for the block range average query engine.
`timescale 1ns / 100ps

module tb_block_range_average_query;

    localparam int N_SAMPLES      = 1024;
    localparam int N_BLOCKS       = 64;
    // Longest quiet stretch of a correct run is the root and clearing pass after a
    // count write; the limit is taken well above it.
    localparam int WATCHDOG_LIMIT = 20000;
    // Cycles left after the last result so that a stray beat would still be seen.
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 205;
    localparam int MAX_PRINTED    = 100;
    // Expectations in flight never exceed two; the ring leaves ample room.
    localparam int EXPECT_DEPTH   = 8;

    // One expected result beat.
    typedef struct packed {
        logic signed [brav_pkg::AVG_W-1:0] average;
        logic                              bad_index;
    } avg_result_t;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port, all inputs known from time zero.
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [brav_pkg::PADDR_W-1:0] paddr   = '0;
    logic [brav_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [brav_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    // Command side.
    logic                              start          = 1'b0;
    logic                              busy;
    logic                              i_kind         = brav_pkg::KIND_LOAD;
    logic signed [brav_pkg::SMP_W-1:0] i_sample_value = '0;
    logic [brav_pkg::IDX_W-1:0]        i_first_index  = '0;
    logic [brav_pkg::IDX_W-1:0]        i_last_index   = '0;

    // Result side.
    logic                              o_valid;
    logic signed [brav_pkg::AVG_W-1:0] o_average;
    logic                              o_bad_index;

    // Predictor state: its own copy of the sample store, block sums and configuration.
    logic signed [brav_pkg::SMP_W-1:0] sample_mirror [N_SAMPLES];
    logic signed [25:0]                block_total   [N_BLOCKS];
    int                                block_len;
    int                                sample_total;

    // Expected beats, oldest at expect_head.
    avg_result_t expected_ring [EXPECT_DEPTH];
    int          expect_head     = 0;
    int          expect_tail     = 0;
    avg_result_t head_average;
    int          mismatch_count  = 0;
    int          quiet_cycles    = 0;
    int          sender_idle_pct = 0;

    always #4 i_clk = ~i_clk;

    block_range_average_query #(
        .MAX_SAMPLES(N_SAMPLES),
        .MAX_BLOCKS (N_BLOCKS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_sample_value(i_sample_value),
        .i_first_index (i_first_index),
        .i_last_index  (i_last_index),
        .o_valid       (o_valid),
        .o_average     (o_average),
        .o_bad_index   (o_bad_index)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Integer square root by counting up; the counts involved are small.
    function automatic int root_floor(int n);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= n) r++;
        return r;
    endfunction

    // A count write keeps only the low 11 bits, clamps them to 1..N_SAMPLES, empties
    // both stores and derives the new block length.
    function automatic void apply_sample_count(logic [brav_pkg::PDATA_W-1:0] wdata);
        int v;
        v = int'(wdata[brav_pkg::CFG_W-1:0]);
        if (v < 1) v = 1;
        if (v > N_SAMPLES) v = N_SAMPLES;
        sample_total = v;
        for (int k = 0; k < N_SAMPLES; k++) sample_mirror[k] = '0;
        for (int k = 0; k < N_BLOCKS; k++) block_total[k] = '0;
        block_len = root_floor(v);
        if (block_len == 0) block_len = 1;
    endfunction

    // Works out the result of one accepted item and updates the mirrored state.
    function automatic avg_result_t compute_average(logic kind,
                                                    logic signed [brav_pkg::SMP_W-1:0] val,
                                                    logic [brav_pkg::IDX_W-1:0] lo_f,
                                                    logic [brav_pkg::IDX_W-1:0] hi_f);
        avg_result_t res;
        int          lo;
        int          hi;
        int          i;
        int          cnt;
        int          blk;
        longint      total;
        longint      quotient;
        res.average   = '0;
        res.bad_index = 1'b0;
        lo    = int'(lo_f);
        hi    = int'(hi_f);
        total = 0;
        cnt   = 0;

        if (kind == brav_pkg::KIND_LOAD) begin
            if (lo >= sample_total) begin
                res.bad_index = 1'b1;
            end else begin
                blk = lo / block_len;
                if (blk < N_BLOCKS) begin
                    block_total[blk] = block_total[blk] + 26'(val) - 26'(sample_mirror[lo]);
                end
                sample_mirror[lo] = val;
            end
            return res;
        end

        if (lo > hi || hi >= sample_total) begin
            res.bad_index = 1'b1;
            return res;
        end

        i = lo;
        // Leading partial block, one sample at a time.
        while (i != 0 && i < hi && (i % block_len) != 0) begin
            total += longint'(sample_mirror[i]);
            i++;
            cnt++;
        end
        // Whole blocks ending before hi, through their sums where the store has them.
        while (i + block_len <= hi) begin
            blk = i / block_len;
            if (blk < N_BLOCKS) begin
                total += longint'(block_total[blk]);
            end else begin
                for (int k = 0; k < block_len; k++) begin
                    total += longint'(sample_mirror[i + k]);
                end
            end
            i   += block_len;
            cnt += block_len;
        end
        // Trailing samples.
        while (i <= hi) begin
            total += longint'(sample_mirror[i]);
            i++;
            cnt++;
        end

        // Division of longints truncates toward zero, as the average requires.
        quotient    = (total * 64'sd256) / longint'(cnt);
        res.average = quotient[brav_pkg::AVG_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Number of expected beats not yet seen.
    function automatic int expected_level();
        return expect_tail - expect_head;
    endfunction

    // Adds one expectation at the young end of the ring.
    function automatic void enqueue_expected(avg_result_t res);
        expected_ring[expect_tail % EXPECT_DEPTH] = res;
        expect_tail++;
    endfunction

    // Sends one item: an optional random gap first, then start is held until the
    // engine takes the beat. The prediction is queued at the accepting edge.
    task automatic send_item(logic kind, logic [brav_pkg::SMP_W-1:0] val,
                             logic [brav_pkg::IDX_W-1:0] lo, logic [brav_pkg::IDX_W-1:0] hi);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_sample_value <= val;
        i_first_index  <= lo;
        i_last_index   <= hi;
        do @(posedge i_clk); while (busy);
        enqueue_expected(compute_average(kind, val, lo, hi));
    endtask

    // Stops sending and waits until every expected result has been seen. Start is
    // lowered before the wait begins, so a following send never lowers and raises it together.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_level() != 0) @(posedge i_clk);
    endtask

    // One APB write of sample_count: setup cycle, then access until pready. The
    // engine then runs its root and clearing pass with busy high, which the next
    // send simply waits out.
    task automatic write_sample_count(logic [brav_pkg::PDATA_W-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= brav_pkg::PADDR_W'(4 * brav_pkg::REG_SAMPLE_COUNT);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_sample_count(wdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Samples are biased toward the two extremes and zero.
    function automatic logic [brav_pkg::SMP_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return r[brav_pkg::SMP_W-1:0];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every beat is matched against the oldest expectation.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_level() == 0) begin
                report_mismatch($sformatf("result beat avg=%0d bad=%0b with nothing expected",
                                          o_average, o_bad_index));
            end else begin
                head_average = expected_ring[expect_head % EXPECT_DEPTH];
                expect_head++;
                if (o_average !== head_average.average)
                    report_mismatch($sformatf("average %0d, expected %0d",
                                              o_average, head_average.average));
                if (o_bad_index !== head_average.bad_index)
                    report_mismatch($sformatf("bad_index %0b, expected %0b",
                                              o_bad_index, head_average.bad_index));
            end
        end
    end

    // Watchdog: counts edges at which no item, result or register write moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || (psel && penable && pwrite && pready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("block_range_average_query regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With the reset count of one, only index zero is usable; everything else is
    // rejected, and the extremes of the sample come back scaled by 256.
    task automatic test_after_reset();
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd0);
        send_item(brav_pkg::KIND_LOAD,  16'h7FFF, 10'd0, 10'd0);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd0);
        send_item(brav_pkg::KIND_LOAD,  16'h1234, 10'd1, 10'd0);
        send_item(brav_pkg::KIND_LOAD,  16'hFFFF, 10'h3FF, 10'h3FF);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd1);
        send_item(brav_pkg::KIND_QUERY, 16'hFFFF, 10'd1, 10'd0);
        send_item(brav_pkg::KIND_LOAD,  16'h8000, 10'd0, 10'd0);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd0);
    endtask

    // A count of zero is taken as one and an all-ones word clamps to the maximum;
    // both writes must also empty the stores. Averages of mixed signs check the
    // truncation toward zero.
    task automatic test_count_limits();
        wait_for_results();
        write_sample_count(32'h0000_0000);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd0);
        wait_for_results();
        write_sample_count(32'hFFFF_FFFF);
        send_item(brav_pkg::KIND_LOAD,  16'h8000, 10'd1023, 10'd0);
        send_item(brav_pkg::KIND_LOAD,  16'h7FFF, 10'd0, 10'd0);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd1023);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd1023, 10'd1023);
        send_item(brav_pkg::KIND_LOAD,  16'h0007, 10'd5, 10'd0);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd1023);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd2, 10'd4);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd1022, 10'd1023);
    endtask

    // Sixteen samples give blocks of four, so a range can have a leading partial
    // block, whole blocks and a trailing run. Upper pwdata bits are set and must be
    // dropped.
    task automatic test_block_walk();
        wait_for_results();
        write_sample_count(32'h0001_0010);
        send_item(brav_pkg::KIND_LOAD,  16'd100,  10'd1, 10'd0);
        send_item(brav_pkg::KIND_LOAD,  16'hFFFD, 10'd6, 10'd0);
        send_item(brav_pkg::KIND_LOAD,  16'd55,   10'd13, 10'd0);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd1, 10'd14);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd3, 10'd3);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd4, 10'd8);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd15);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd15, 10'd15);
        send_item(brav_pkg::KIND_QUERY, 16'h0000, 10'd0, 10'd16);
    endtask

    // Random traffic over several counts. Most items are in range, so that loads
    // land and queries walk real data; about one in ten is raw noise over the
    // whole field ranges. Each phase pauses once half way for every result.
    task automatic test_random_traffic();
        int                          phase_count [9] = '{2, 1024, 5, 100, 0, 16, 1023, 3, 0};
        int                          idle_modes  [4] = '{0, 87, 0, 25};
        logic [brav_pkg::PDATA_W-1:0] wdata;
        logic [brav_pkg::IDX_W-1:0]   lo;
        logic [brav_pkg::IDX_W-1:0]   hi;
        logic [brav_pkg::IDX_W-1:0]   tmp;
        logic [31:0]                  r;
        logic [31:0]                  r_val;
        logic [31:0]                  r_lo;
        logic [31:0]                  r_hi;
        int                           pick;
        for (int p = 0; p < 9; p++) begin
            wait_for_results();
            // The last phase takes a count drawn at random.
            wdata = (p == 8) ? $urandom_range(1, N_SAMPLES) : phase_count[p];
            write_sample_count(wdata);
            sender_idle_pct = idle_modes[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) wait_for_results();
                pick  = $urandom_range(99);
                r_val = $urandom;
                r_lo  = $urandom_range(sample_total - 1);
                r_hi  = $urandom_range(sample_total - 1);
                if (pick < 45) begin
                    lo = r_lo[brav_pkg::IDX_W-1:0];
                    send_item(brav_pkg::KIND_LOAD, pick_sample(), lo,
                              r_val[brav_pkg::IDX_W-1:0]);
                end else if (pick < 90) begin
                    lo = r_lo[brav_pkg::IDX_W-1:0];
                    hi = r_hi[brav_pkg::IDX_W-1:0];
                    if (lo > hi) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    send_item(brav_pkg::KIND_QUERY, r_val[brav_pkg::SMP_W-1:0], lo, hi);
                end else begin
                    r    = $urandom;
                    r_lo = $urandom;
                    r_hi = $urandom;
                    send_item(r[0], r_val[brav_pkg::SMP_W-1:0],
                              r_lo[brav_pkg::IDX_W-1:0], r_hi[brav_pkg::IDX_W-1:0]);
                end
            end
        end
        sender_idle_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        apply_sample_count(32'd1);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_count_limits();
        test_block_walk();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_level() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_level()));

        if (mismatch_count == 0) begin
            $display("block_range_average_query regression: pass");
        end else begin
            $display("block_range_average_query regression: fail");
        end
        $finish;
    end

endmodule

FILE: block_range_average_query.f
rtl/brav_pkg.sv
rtl/brav_ram.sv
rtl/block_range_average_query.sv
tb/tb_block_range_average_query.sv
